// ===== design/swmq_pkg.sv =====
// ----------------------------------------------------------------------------
// swmq_pkg
// Command and status codes and beat types for the LIFO stack with mode query.
// ----------------------------------------------------------------------------
package swmq_pkg;

    // command codes
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // width of the reported repeat count
    localparam int unsigned REPEAT_W = 7;

    // request beat
    typedef struct packed {
        logic        [1:0]  command;
        logic signed [31:0] push_value;
    } req_beat_t;

    // response beat
    typedef struct packed {
        logic signed [31:0]         result_value;
        logic        [REPEAT_W-1:0] repeat_count;
        logic        [1:0]          status;
    } rsp_beat_t;

endpackage

// ===== design/swmq_if.sv =====
// ----------------------------------------------------------------------------
// swmq_req_if / swmq_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface swmq_req_if
    import swmq_pkg::*;
;
    logic      valid;
    logic      ready;
    req_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swmq_rsp_if
    import swmq_pkg::*;
;
    logic      valid;
    logic      ready;
    rsp_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/stack_with_mode_query_top.sv =====
// ----------------------------------------------------------------------------
// stack_with_mode_query_top
// Bounded LIFO stack of signed 32-bit values with a most-frequent-value query.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | beats
//  req     | in  | command, push_value                       | one per command
//  rsp     | out | result_value, repeat_count, status        | one per request
//
//  push writes the store directly; pop waits in S_POP for one registered read.
//  query walks the single-read-port store with one compare unit: each
//  candidate is fetched (S_QLOAD, S_QCAPT), then counted against every entry.
//  reset clears only state, fill, out valid; store is never read unwritten.
//  req.ready is high only while the sequencer is idle; a finished beat waits
//  in the output register while rsp.ready is low and the next beat is taken.
// ----------------------------------------------------------------------------
module stack_with_mode_query_top
    import swmq_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    swmq_req_if.sink      req,
    swmq_rsp_if.source    rsp
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(DEPTH);

    // sequencer state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_QLOAD = 3'd2;
    localparam logic [2:0] S_QCAPT = 3'd3;
    localparam logic [2:0] S_QSCAN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]  c_reg, c_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [31:0] cand_reg, cand_next;
    logic signed [31:0] best_val_reg, best_val_next;
    logic [CNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    rsp_beat_t          out_data_reg, out_data_next;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;

    logic               req_fire;
    logic [CNT_W-1:0]   fill_m1;
    logic               match;
    logic [CNT_W-1:0]   cnt_sum;
    logic               scan_last;
    logic               out_load;
    logic [CNT_W+REPEAT_W-1:0] cnt_wide;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign fill_m1   = fill_reg - CNT_W'(1);
    assign match     = (rd_data_reg == cand_reg);
    assign cnt_sum   = cnt_reg + CNT_W'(match);
    assign scan_last = (k_reg == fill_m1[ADDR_W-1:0]);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign cnt_wide  = {{REPEAT_W{1'b0}}, best_cnt_reg};
    assign wr_addr   = fill_reg[ADDR_W-1:0];

    // stack store, single write and single registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= req.data.push_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        cand_next       = cand_reg;
        best_val_next   = best_val_reg;
        best_cnt_next   = best_cnt_reg;
        res_status_next = res_status_reg;
        rd_addr         = c_reg;
        mem_we          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = fill_m1[ADDR_W-1:0];
                if (req_fire)
                begin
                    best_val_next   = '0;
                    best_cnt_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (req.data.command)
                        CMD_PUSH:
                        begin
                            if (fill_reg == FULL_LEVEL)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                fill_next  = fill_m1;
                                state_next = S_POP;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                c_next     = fill_m1[ADDR_W-1:0];
                                state_next = S_QLOAD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                best_val_next = rd_data_reg;
                state_next    = S_DONE;
            end
            // fetch candidate at c
            S_QLOAD:
            begin
                rd_addr    = c_reg;
                state_next = S_QCAPT;
            end
            // latch candidate, start counting from the bottom
            S_QCAPT:
            begin
                cand_next  = rd_data_reg;
                rd_addr    = '0;
                k_next     = '0;
                cnt_next   = '0;
                state_next = S_QSCAN;
            end
            // one compare per cycle against entry k
            S_QSCAN:
            begin
                cnt_next = cnt_sum;
                rd_addr  = k_reg + ADDR_W'(1);
                k_next   = k_reg + ADDR_W'(1);
                if (scan_last)
                begin
                    if (cnt_sum > best_cnt_reg)
                    begin
                        best_cnt_next = cnt_sum;
                        best_val_next = cand_reg;
                    end
                    if (c_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        c_next     = c_reg - ADDR_W'(1);
                        state_next = S_QLOAD;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.result_value = best_val_reg;
            out_data_next.repeat_count = cnt_wide[REPEAT_W-1:0];
            out_data_next.status       = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        c_reg          <= c_next;
        k_reg          <= k_next;
        cnt_reg        <= cnt_next;
        cand_reg       <= cand_next;
        best_val_reg   <= best_val_next;
        best_cnt_reg   <= best_cnt_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    // fill level never passes capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_LEVEL)
        else $error("fill level above capacity");

    // accepted push below capacity grows the stack by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.data.command == CMD_PUSH && fill_reg != FULL_LEVEL)
        |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    // pop on empty leaves the stack empty and reports empty
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.data.command == CMD_POP && fill_reg == '0)
        |=> (fill_reg == '0 && res_status_reg == ST_EMPTY))
        else $error("pop on empty changed the stack");

    // a nonzero count only goes out with status ok
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && best_cnt_reg != '0) |-> res_status_reg == ST_OK)
        else $error("count reported with error status");

    // the count scan never runs past the stored entries
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QSCAN) |-> (CNT_W'(k_reg) < fill_reg))
        else $error("scan index beyond fill level");

endmodule

// ===== test/stack_with_mode_query_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_mode_query_top_test
// Self-checking bench for the LIFO stack with most-frequent-value query.
// Every accepted request beat is run through a behavioral stack model. The
// model predicts the response beat, and each response is checked field by
// field. Traffic is a directed opening, fill-to-full passes and a random walk
// of push/pop/query. It runs under four mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
import swmq_pkg::*;

// behavioral stack model plus queue of predicted response beats
class stack_mode_tracker #(int unsigned DEPTH_N = 64);
    logic signed [31:0] stack_mem [DEPTH_N];
    int unsigned        fill_level;
    rsp_beat_t          pending_responses [$];
    int unsigned        mismatch_count;
    int unsigned        checked_count;
    int unsigned        query_count;
    int unsigned        empty_count;
    int unsigned        full_count;
    int unsigned        peak_fill;

    function new();
        fill_level     = 0;
        mismatch_count = 0;
        checked_count  = 0;
        query_count    = 0;
        empty_count    = 0;
        full_count     = 0;
        peak_fill      = 0;
    endfunction

    task report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // update the stack for one accepted request and queue its response
    function void note_request(input req_beat_t beat);
        rsp_beat_t          expected;
        int unsigned        hits;
        int unsigned        best_hits;
        logic signed [31:0] best_value;
        expected        = '0;
        expected.status = ST_OK;
        case (beat.command)
            CMD_PUSH:
            begin
                if (fill_level >= DEPTH_N)
                begin
                    expected.status = ST_FULL;
                end
                else
                begin
                    stack_mem[fill_level] = beat.push_value;
                    fill_level++;
                end
            end
            CMD_POP:
            begin
                if (fill_level == 0)
                begin
                    expected.status = ST_EMPTY;
                end
                else
                begin
                    fill_level--;
                    expected.result_value = stack_mem[fill_level];
                end
            end
            CMD_QUERY:
            begin
                query_count++;
                if (fill_level == 0)
                begin
                    expected.status = ST_EMPTY;
                end
                else
                begin
                    best_hits  = 0;
                    best_value = '0;
                    // candidates from the top down, strictly larger count wins
                    for (int cand = int'(fill_level) - 1; cand >= 0; cand--)
                    begin
                        hits = 0;
                        for (int scan = 0; scan < int'(fill_level); scan++)
                        begin
                            if (stack_mem[scan] == stack_mem[cand])
                                hits++;
                        end
                        if (hits > best_hits)
                        begin
                            best_hits  = hits;
                            best_value = stack_mem[cand];
                        end
                    end
                    expected.result_value = best_value;
                    expected.repeat_count = REPEAT_W'(best_hits);
                end
            end
            default:
            begin
                // unused code leaves the stack alone
            end
        endcase
        if (expected.status == ST_EMPTY)
            empty_count++;
        if (expected.status == ST_FULL)
            full_count++;
        if (fill_level > peak_fill)
            peak_fill = fill_level;
        pending_responses.push_back(expected);
    endfunction

    // compare one response beat with the oldest prediction
    task check_response(input rsp_beat_t got);
        rsp_beat_t want;
        if (pending_responses.size() == 0)
        begin
            report_mismatch($sformatf("response beat with none expected: value %0d count %0d status %0d",
                                      got.result_value, got.repeat_count, got.status));
            return;
        end
        want = pending_responses.pop_front();
        checked_count++;
        if (got.result_value !== want.result_value)
            report_mismatch($sformatf("beat %0d result_value %0d, expected %0d",
                                      checked_count, got.result_value, want.result_value));
        if (got.repeat_count !== want.repeat_count)
            report_mismatch($sformatf("beat %0d repeat_count %0d, expected %0d",
                                      checked_count, got.repeat_count, want.repeat_count));
        if (got.status !== want.status)
            report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                      checked_count, got.status, want.status));
    endtask
endclass

module stack_with_mode_query_top_test;
    localparam int unsigned STACK_DEPTH     = 64;
    localparam int unsigned WALK_ITEMS      = 60;
    localparam int unsigned SETTLE_CYCLES   = 50;
    // worst case: ~600 beats, each a full-depth query, plus long sender gaps
    // and receiver stalls, taken about four times over
    localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;

    localparam logic [1:0]         CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;

    logic            clk;
    logic            rst_n;
    int unsigned     sender_idle_pct;
    int unsigned     receiver_stall_pct;
    int unsigned     items_sent;
    longint unsigned cycle_count = 0;

    stack_mode_tracker #(STACK_DEPTH) tracker;

    swmq_req_if req_ch ();
    swmq_rsp_if rsp_ch ();

    stack_with_mode_query_top #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            tracker.check_response(rsp_ch.data);
    end

    // present one request beat and hold it until accepted
    task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] value);
        req_beat_t beat;
        beat.command    = cmd;
        beat.push_value = value;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= beat;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(beat);
        if (cmd != CMD_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // stop sending until every predicted response has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending_responses.size() != 0);
    endtask

    // mostly a few repeating values and the extremes, sometimes anything
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       pick_value = VAL_MAX;
            1:       pick_value = VAL_MIN;
            2:       pick_value = '0;
            3:       pick_value = -32'sd1;
            4, 5, 6: pick_value = $urandom_range(3);
            default: pick_value = $urandom;
        endcase
    endfunction

    // random walk biased to keep the stack shallow
    task automatic random_step();
        int unsigned roll;
        int unsigned push_weight;
        roll        = $urandom_range(99);
        push_weight = (tracker.fill_level > 16) ? 30 : 50;
        if (roll < push_weight)
            send_request(CMD_PUSH, pick_value());
        else if (roll < 85)
            send_request(CMD_POP, $urandom);
        else if (roll < 97)
            send_request(CMD_QUERY, $urandom);
        else
            send_request(CMD_UNUSED, $urandom);
    endtask

    // push to capacity and past it, query at full depth, then pop past empty
    task automatic fill_and_empty(input logic signed [31:0] base, input int unsigned spread);
        while (tracker.fill_level < STACK_DEPTH)
            send_request(CMD_PUSH, base + $urandom_range(spread));
        send_request(CMD_PUSH, $urandom);
        send_request(CMD_PUSH, $urandom);
        send_request(CMD_QUERY, $urandom);
        while (tracker.fill_level > 0)
            send_request(CMD_POP, $urandom);
        send_request(CMD_POP, $urandom);
        send_request(CMD_QUERY, $urandom);
    endtask

    // stimulus
    initial
    begin
        tracker            = new();
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.data        = '0;
        rsp_ch.ready       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty stack and the unused code
        send_request(CMD_POP, '0);
        send_request(CMD_QUERY, '0);
        send_request(CMD_UNUSED, VAL_MAX);
        // single entry query covers the bottom slot
        send_request(CMD_PUSH, 32'sd42);
        send_request(CMD_QUERY, '0);
        send_request(CMD_POP, '0);
        // all distinct: top entry wins the tie
        send_request(CMD_PUSH, VAL_MAX);
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_PUSH, -32'sd1);
        send_request(CMD_PUSH, '0);
        send_request(CMD_QUERY, '0);
        // clear winner, then a two-way tie settled by position
        send_request(CMD_PUSH, VAL_MIN);
        send_request(CMD_QUERY, '0);
        send_request(CMD_PUSH, VAL_MAX);
        send_request(CMD_QUERY, -32'sd1);
        // unwind past empty
        repeat (6) send_request(CMD_POP, '0);
        send_request(CMD_POP, '0);
        send_request(CMD_QUERY, '0);
        hold_until_drained();

        // random phases with different idle mixes
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            // one value everywhere gives the largest repeat count
            if (phase == 0)
                fill_and_empty(VAL_MIN, 0);
            if (phase == 3)
                fill_and_empty(-32'sd2, 5);
            repeat (WALK_ITEMS) random_step();
            hold_until_drained();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_responses.size() != 0)
            tracker.report_mismatch($sformatf("%0d responses never arrived",
                                              tracker.pending_responses.size()));

        $display("sent %0d commands over four idle mixes, %0d response beats checked",
                 items_sent, tracker.checked_count);
        $display("%0d queries, %0d empty and %0d full statuses, deepest fill %0d of %0d",
                 tracker.query_count, tracker.empty_count, tracker.full_count,
                 tracker.peak_fill, STACK_DEPTH);
        if (tracker.mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
